>>> design/tet4_to_tet10_midside_nodes_unit_assert.svh
// Assertion macros for the tet4-to-tet10 midside node unit.
// Used by design files through a plain include; needs clk and arst_n in scope.
`ifndef TET4_TO_TET10_MIDSIDE_NODES_UNIT_ASSERT_SVH
`define TET4_TO_TET10_MIDSIDE_NODES_UNIT_ASSERT_SVH
`ifndef SYNTH
`define T4T10_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define T4T10_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define T4T10_ASSERT_NOW(lbl, ante, cons, msg)
`define T4T10_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/t4t10_pkg.sv
// Shared types, constants and helper functions for the tet4-to-tet10 unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package t4t10_pkg;

	localparam int IW      = 16;                 // node index width
	localparam int NODE_AW = IW;
	localparam int NODE_N  = 1 << NODE_AW;
	localparam int EDGE_AW = 16;
	localparam int EDGE_N  = 1 << EDGE_AW;
	localparam int CNT_W   = 17;
	localparam int CW      = 32;                 // coordinate width
	localparam int DW      = CW + 1;             // corner difference
	localparam int PW      = 2 * DW + 1;         // 2x2 minor
	localparam int MW      = PW + DW;            // multiplier product
	localparam int VW      = MW + 2;             // volume sum

	localparam logic [CNT_W-1:0]   NODE_CAP   = CNT_W'(NODE_N);
	localparam logic [CNT_W-1:0]   EDGE_CAP   = CNT_W'(EDGE_N);
	localparam logic [EDGE_AW-1:0] CNT_MAX    = '1;
	localparam int                 MUL_STEPS  = DW;
	localparam logic [3:0]         LAST_SLOT  = 4'd9;
	localparam logic [2:0]         LAST_EDGE  = 3'd5;
	localparam logic [3:0]         FIRST_MID  = 4'd4;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_CORNER    = 2'd1,
		ERR_NODE_FULL = 2'd2,
		ERR_EDGE_FULL = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		EM_NODE    = 3'd0,
		EM_ERR     = 3'd1,
		EM_CORNER  = 3'd2,
		EM_MID_NEW = 3'd3,
		EM_MID_RD  = 3'd4
	} emit_sel_t;

	typedef enum logic [1:0] {
		MOP_P    = 2'd0,
		MOP_D    = 2'd1,
		MOP_VSET = 2'd2,
		MOP_VADD = 2'd3
	} mul_op_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] a;
	} node_ent_t;

	typedef struct packed {
		logic          v;
		logic [31:0]   key;
		logic [IW-1:0] node;
	} edge_ent_t;

	typedef struct packed {
		logic               load_in;
		logic               node_write;
		logic               clr;
		logic [EDGE_AW-1:0] clr_addr;
		logic               nrd_corner;
		logic               nrd_res;
		logic [1:0]         k;
		logic               cap_en;
		logic [1:0]         cap_k;
		logic               diff;
		logic               mul_load;
		logic               mul_step;
		logic               mul_last;
		logic               mul_fin;
		mul_op_t            mop;
		logic [3:0]         p;
		logic               swap;
		logic [2:0]         e;
		logic               lk_dup;
		logic               lk_hit;
		logic               lk_miss;
		logic               probe_first;
		logic               probe_next;
		logic               mid_write;
		logic               ins_write;
		logic               emit;
		emit_sel_t          esel;
		err_t               err;
		logic [3:0]         slot;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic corners_ok;
		logic node_full;
		logic dup_found;
		logic ent_hit;
		logic ent_empty;
		logic cap_node_err;
		logic cap_edge_err;
		logic fresh_e;
	} sts_t;

	// edge order: (0,1) (2,1) (0,2) (0,3) (3,1) (3,2)
	function automatic logic [1:0] edge_from(input logic [2:0] e);
		logic [1:0] r;
		unique case (e)
			3'd0: r = 2'd0;
			3'd1: r = 2'd2;
			3'd2: r = 2'd0;
			3'd3: r = 2'd0;
			3'd4: r = 2'd3;
			3'd5: r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] edge_to(input logic [2:0] e);
		logic [1:0] r;
		unique case (e)
			3'd0: r = 2'd1;
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd3;
			3'd4: r = 2'd1;
			3'd5: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [EDGE_AW-1:0] edge_hash(input logic [31:0] key);
		return key[15:0] ^ key[31:16] ^ {key[26:16], key[31:27]};
	endfunction

endpackage
`default_nettype wire

>>> design/tet4_to_tet10_midside_nodes_unit.sv
// Top level of the tet4-to-tet10 midside node unit: APB register and wiring.
// Depends on t4t10_pkg, t4t10_ctrl and t4t10_dp.
//
//  channel   handshake            payload
//  request   in_valid / in_stall  mode, coord_x..z, node_attribute, corner_a..d
//  result    out_valid/out_stall  slot, node_index, is_new, out_x..z, out_attribute, last, error
//  config    APB psel/penable     attributes_present at byte address 0
//
// Node load: the node is written and emitted once the result register is free. A tetrahedron
// checks its corners, reads them, forms the differences and runs the bit-serial determinant
// multiplier (9 products, each: load, 33 shift-add steps, accumulate), then looks up each
// edge by hash probing; an edge repeated within the element skips the table lookup.
// After reset the edge table is cleared, one entry a cycle, for all 65536 entries; in_stall is
// high during the pass. The result register holds while out_stall is high.
`default_nettype none
module tet4_to_tet10_midside_nodes_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] node_attribute,
	input  logic [15:0]        corner_a,
	input  logic [15:0]        corner_b,
	input  logic [15:0]        corner_c,
	input  logic [15:0]        corner_d,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         slot,
	output logic [15:0]        node_index,
	output logic               is_new,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_attribute,
	output logic               last,
	output logic [1:0]         error
);
	import t4t10_pkg::*;

	localparam logic [2:0] ADDR_ATTR = 3'd0;

	cmd_t cmd;
	sts_t sts;
	logic attr_q;
	logic reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_ATTR) ? {31'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= 1'b0;
		end else if (reg_wr && paddr == ADDR_ATTR) begin
			attr_q <= pwdata[0];
		end
	end

	t4t10_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	t4t10_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.attr_en        (attr_q),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.node_attribute (node_attribute),
		.corner_a       (corner_a),
		.corner_b       (corner_b),
		.corner_c       (corner_c),
		.corner_d       (corner_d),
		.slot           (slot),
		.node_index     (node_index),
		.is_new         (is_new),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_attribute  (out_attribute),
		.last           (last),
		.error          (error)
	);

endmodule
`default_nettype wire

>>> design/t4t10_ctrl.sv
// Controller state machine for the tet4-to-tet10 unit.
// Depends on t4t10_pkg and the assertion macro header.
`default_nettype none
`include "tet4_to_tet10_midside_nodes_unit_assert.svh"
module t4t10_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	output logic              out_valid,
	input  logic              out_stall,
	output t4t10_pkg::cmd_t   cmd,
	input  t4t10_pkg::sts_t   sts
);
	import t4t10_pkg::*;

	typedef enum logic [16:0] {
		S_CLR  = 17'h00001,
		S_IDLE = 17'h00002,
		S_NODE = 17'h00004,
		S_CHK  = 17'h00008,
		S_RDC  = 17'h00010,
		S_DIFF = 17'h00020,
		S_MLD  = 17'h00040,
		S_MRUN = 17'h00080,
		S_MFIN = 17'h00100,
		S_SWAP = 17'h00200,
		S_LK   = 17'h00400,
		S_PRB  = 17'h00800,
		S_CAP  = 17'h01000,
		S_OUT  = 17'h02000,
		S_INS  = 17'h04000,
		S_RDW  = 17'h08000,
		S_ERR  = 17'h10000
	} state_t;

	state_t             state_q, state_d;
	logic [EDGE_AW-1:0] cnt_q, cnt_d;
	logic [3:0]         p_q, p_d;
	logic [2:0]         e_q, e_d;
	logic [3:0]         k_q, k_d;
	err_t               err_q, err_d;
	logic               out_valid_q;
	logic               out_free;
	logic               in_acc;
	logic               out_phase;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_phase = (state_q == S_OUT) || (state_q == S_INS) || (state_q == S_RDW);

	always_comb begin
		cmd          = '0;
		cmd.clr_addr = cnt_q;
		cmd.k        = k_q[1:0];
		cmd.cap_k    = 2'(cnt_q[1:0] - 2'd1);
		cmd.p        = p_q;
		cmd.e        = out_phase ? 3'(k_q - FIRST_MID) : e_q;
		cmd.err      = err_q;
		cmd.slot     = k_q;
		cmd.last     = (k_q == LAST_SLOT);
		cmd.esel     = EM_ERR;
		unique case (p_q)
			4'd0, 4'd3, 4'd6: cmd.mop = MOP_P;
			4'd1, 4'd4, 4'd7: cmd.mop = MOP_D;
			4'd2:             cmd.mop = MOP_VSET;
			default:          cmd.mop = MOP_VADD;
		endcase
		state_d = state_q;
		cnt_d   = cnt_q;
		p_d     = p_q;
		e_d     = e_q;
		k_d     = k_q;
		err_d   = err_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_MAX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = mode ? S_CHK : S_NODE;
				end
			end
			S_NODE: begin
				if (sts.node_full) begin
					err_d   = ERR_NODE_FULL;
					state_d = S_ERR;
				end else if (out_free) begin
					cmd.node_write = 1'b1;
					cmd.emit       = 1'b1;
					cmd.esel       = EM_NODE;
					state_d        = S_IDLE;
				end
			end
			S_CHK: begin
				cnt_d = '0;
				if (!sts.corners_ok) begin
					err_d   = ERR_CORNER;
					state_d = S_ERR;
				end else begin
					state_d = S_RDC;
				end
			end
			S_RDC: begin
				// read corner n while capturing corner n-1
				cmd.k          = cnt_q[1:0];
				cmd.nrd_corner = (cnt_q < EDGE_AW'(4));
				cmd.cap_en     = (cnt_q != '0);
				cnt_d          = cnt_q + 1'b1;
				if (cnt_q == EDGE_AW'(4)) state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				p_d      = '0;
				state_d  = S_MLD;
			end
			S_MLD: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_MRUN;
			end
			S_MRUN: begin
				cmd.mul_step = 1'b1;
				cmd.mul_last = (cnt_q == EDGE_AW'(MUL_STEPS - 1));
				cnt_d        = cnt_q + 1'b1;
				if (cmd.mul_last) state_d = S_MFIN;
			end
			S_MFIN: begin
				cmd.mul_fin = 1'b1;
				p_d         = p_q + 1'b1;
				state_d     = (p_q == 4'd8) ? S_SWAP : S_MLD;
			end
			S_SWAP: begin
				cmd.swap = 1'b1;
				e_d      = '0;
				state_d  = S_LK;
			end
			S_LK: begin
				cnt_d = '0;
				if (sts.dup_found) begin
					cmd.lk_dup = 1'b1;
					e_d        = e_q + 1'b1;
					state_d    = (e_q == LAST_EDGE) ? S_CAP : S_LK;
				end else begin
					cmd.probe_first = 1'b1;
					state_d         = S_PRB;
				end
			end
			S_PRB: begin
				if (sts.ent_hit || sts.ent_empty || cnt_q == CNT_MAX) begin
					cmd.lk_hit  = sts.ent_hit;
					cmd.lk_miss = !sts.ent_hit;
					e_d         = e_q + 1'b1;
					state_d     = (e_q == LAST_EDGE) ? S_CAP : S_LK;
				end else begin
					cmd.probe_next = 1'b1;
					cnt_d          = cnt_q + 1'b1;
				end
			end
			S_CAP: begin
				k_d = '0;
				priority if (sts.cap_node_err) begin
					err_d   = ERR_NODE_FULL;
					state_d = S_ERR;
				end else if (sts.cap_edge_err) begin
					err_d   = ERR_EDGE_FULL;
					state_d = S_ERR;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (k_q < FIRST_MID) begin
					if (out_free) begin
						cmd.emit = 1'b1;
						cmd.esel = EM_CORNER;
						k_d      = k_q + 1'b1;
					end
				end else if (sts.fresh_e) begin
					if (out_free) begin
						cmd.emit        = 1'b1;
						cmd.esel        = EM_MID_NEW;
						cmd.mid_write   = 1'b1;
						cmd.probe_first = 1'b1;
						state_d         = S_INS;
					end
				end else begin
					cmd.nrd_res = 1'b1;
					state_d     = S_RDW;
				end
			end
			S_INS: begin
				// walk to the first free slot of the edge table
				if (sts.ent_empty) begin
					cmd.ins_write = 1'b1;
					k_d           = k_q + 1'b1;
					state_d       = (k_q == LAST_SLOT) ? S_IDLE : S_OUT;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_RDW: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_MID_RD;
					k_d      = k_q + 1'b1;
					state_d  = (k_q == LAST_SLOT) ? S_IDLE : S_OUT;
				end
			end
			S_ERR: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_ERR;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			p_q         <= '0;
			e_q         <= '0;
			k_q         <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			p_q     <= p_d;
			e_q     <= e_d;
			k_q     <= k_d;
			err_q   <= err_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`T4T10_ASSERT_NEXT(a_busy_after_req, in_acc, in_stall, "request accepted but unit not busy")
	`T4T10_ASSERT_NOW(a_emit_room, cmd.emit, out_free, "result emitted over a pending one")
	`T4T10_ASSERT_NEXT(a_probe_bound, state_q == S_PRB && cnt_q == CNT_MAX, state_q != S_PRB,
		"edge probe ran past table depth")

endmodule
`default_nettype wire

>>> design/t4t10_dp.sv
// Datapath: node store, edge hash table, volume-sign multiplier, output register.
// Depends on t4t10_pkg; driven by t4t10_ctrl commands.
`default_nettype none
module t4t10_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  t4t10_pkg::cmd_t      cmd,
	output t4t10_pkg::sts_t      sts,
	input  logic                 attr_en,
	input  logic signed [31:0]   coord_x,
	input  logic signed [31:0]   coord_y,
	input  logic signed [31:0]   coord_z,
	input  logic signed [31:0]   node_attribute,
	input  logic [15:0]          corner_a,
	input  logic [15:0]          corner_b,
	input  logic [15:0]          corner_c,
	input  logic [15:0]          corner_d,
	output logic [3:0]           slot,
	output logic [15:0]          node_index,
	output logic                 is_new,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [31:0]   out_z,
	output logic signed [31:0]   out_attribute,
	output logic                 last,
	output logic [1:0]           error
);
	import t4t10_pkg::*;

	node_ent_t          nmem [NODE_N];
	edge_ent_t          emem [EDGE_N];

	node_ent_t          in_node_q;
	logic [IW-1:0]      c_q [4];
	node_ent_t          cdat_q [4];
	node_ent_t          nrd_q;
	edge_ent_t          erd_q;
	logic [EDGE_AW-1:0] prb_addr_q;
	logic [IW-1:0]      res_q [6];
	logic [5:0]         fresh_q;
	logic [2:0]         added_q;
	logic [CNT_W-1:0]   node_count_q;
	logic [CNT_W-1:0]   edge_count_q;

	logic [DW-1:0]      dx_q [3];
	logic [DW-1:0]      dy_q [3];
	logic [DW-1:0]      dz_q [3];
	logic [PW-1:0]      p_q, d_q;
	logic [VW-1:0]      v_q;
	logic [MW-1:0]      mca_q, acc_q;
	logic [DW-1:0]      mb_q;

	logic [31:0]        key_all [6];
	logic [31:0]        cur_key;
	logic [IW-1:0]      dup_res;
	logic               dup_found;
	node_ent_t          na, nb, mid_ent;
	logic [PW-1:0]      mul_a;
	logic [DW-1:0]      mul_b;
	logic [MW-1:0]      mca_add;
	logic [CNT_W-1:0]   node_need, edge_need;

	logic               ewe, ere, nwe, nre;
	logic [EDGE_AW-1:0] ewa, era;
	edge_ent_t          ewd;
	logic [NODE_AW-1:0] nwa, nra;
	node_ent_t          nwd;

	logic [3:0]         o_slot;
	logic [IW-1:0]      o_idx;
	logic               o_new;
	node_ent_t          o_dat;
	logic               o_last;
	logic [1:0]         o_err;

	function automatic logic [31:0] edge_key(input logic [IW-1:0] a, input logic [IW-1:0] b);
		return (a < b) ? {a, b} : {b, a};
	endfunction

	function automatic logic signed [CW-1:0] half_floor(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		return s[CW:1];
	endfunction

	function automatic logic [DW-1:0] sdiff(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	function automatic logic signed [CW-1:0] shown(input logic signed [CW-1:0] a, input logic en);
		return en ? a : '0;
	endfunction

	// edge keys of the current corner order
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			key_all[j] = edge_key(c_q[edge_from(3'(j))], c_q[edge_to(3'(j))]);
		end
		cur_key = key_all[cmd.e];
	end

	// an edge seen earlier in this element and created here reuses that node
	always_comb begin
		dup_found = 1'b0;
		dup_res   = '0;
		for (int j = 0; j < 6; j++) begin
			if (!dup_found && 3'(j) < cmd.e && fresh_q[j] && key_all[j] == cur_key) begin
				dup_found = 1'b1;
				dup_res   = res_q[j];
			end
		end
	end

	always_comb begin
		na                = cdat_q[edge_from(cmd.e)];
		nb                = cdat_q[edge_to(cmd.e)];
		mid_ent.x         = half_floor(na.x, nb.x);
		mid_ent.y         = half_floor(na.y, nb.y);
		mid_ent.z         = half_floor(na.z, nb.z);
		mid_ent.a         = (attr_en && na.a == nb.a) ? na.a : '0;
	end

	assign node_need = node_count_q + CNT_W'(added_q);
	assign edge_need = edge_count_q + CNT_W'(added_q);

	always_comb begin
		sts.corners_ok   = ({1'b0, c_q[0]} < node_count_q) && ({1'b0, c_q[1]} < node_count_q)
			&& ({1'b0, c_q[2]} < node_count_q) && ({1'b0, c_q[3]} < node_count_q);
		sts.node_full    = (node_count_q >= NODE_CAP);
		sts.dup_found    = dup_found;
		sts.ent_hit      = erd_q.v && (erd_q.key == cur_key);
		sts.ent_empty    = !erd_q.v;
		sts.cap_node_err = (node_need > NODE_CAP);
		sts.cap_edge_err = (edge_need > EDGE_CAP);
		sts.fresh_e      = fresh_q[cmd.e];
	end

	// edge hash table, linear probing
	assign ewe = cmd.clr || cmd.ins_write;
	assign ewa = cmd.clr ? cmd.clr_addr : prb_addr_q;
	assign ewd = cmd.clr ? '0 : '{v: 1'b1, key: cur_key, node: res_q[cmd.e]};
	assign ere = cmd.probe_first || cmd.probe_next;
	assign era = cmd.probe_first ? edge_hash(cur_key) : prb_addr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (ewe) emem[ewa] <= ewd;
		if (ere) begin
			erd_q      <= emem[era];
			prb_addr_q <= era;
		end
	end

	// node store
	assign nwe = cmd.node_write || cmd.mid_write;
	assign nwa = cmd.node_write ? node_count_q[NODE_AW-1:0] : res_q[cmd.e];
	assign nwd = cmd.node_write ? in_node_q : mid_ent;
	assign nre = cmd.nrd_corner || cmd.nrd_res;
	assign nra = cmd.nrd_corner ? c_q[cmd.k] : res_q[cmd.e];

	always_ff @(posedge clk) begin
		if (nwe) nmem[nwa] <= nwd;
		if (nre) nrd_q <= nmem[nra];
	end

	// multiplier operand select for the 3x3 determinant
	always_comb begin
		unique case (cmd.p)
			4'd0: begin mul_a = PW'(signed'(dy_q[1])); mul_b = dz_q[2]; end
			4'd1: begin mul_a = PW'(signed'(dy_q[2])); mul_b = dz_q[1]; end
			4'd2: begin mul_a = d_q;                   mul_b = dx_q[0]; end
			4'd3: begin mul_a = PW'(signed'(dx_q[2])); mul_b = dz_q[1]; end
			4'd4: begin mul_a = PW'(signed'(dx_q[1])); mul_b = dz_q[2]; end
			4'd5: begin mul_a = d_q;                   mul_b = dy_q[0]; end
			4'd6: begin mul_a = PW'(signed'(dx_q[1])); mul_b = dy_q[2]; end
			4'd7: begin mul_a = PW'(signed'(dx_q[2])); mul_b = dy_q[1]; end
			default: begin mul_a = d_q;                mul_b = dz_q[0]; end
		endcase
	end

	// sign bit of the multiplier carries negative weight
	assign mca_add = cmd.mul_last ? acc_q - mca_q : acc_q + mca_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_node_q <= '{x: coord_x, y: coord_y, z: coord_z, a: node_attribute};
			c_q[0]    <= corner_a;
			c_q[1]    <= corner_b;
			c_q[2]    <= corner_c;
			c_q[3]    <= corner_d;
		end
		if (cmd.cap_en) cdat_q[cmd.cap_k] <= nrd_q;
		if (cmd.diff) begin
			for (int i = 0; i < 3; i++) begin
				dx_q[i] <= sdiff(cdat_q[i+1].x, cdat_q[0].x);
				dy_q[i] <= sdiff(cdat_q[i+1].y, cdat_q[0].y);
				dz_q[i] <= sdiff(cdat_q[i+1].z, cdat_q[0].z);
			end
		end
		if (cmd.mul_load) begin
			mca_q <= MW'(signed'(mul_a));
			mb_q  <= mul_b;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			if (mb_q[0]) acc_q <= mca_add;
			mca_q <= mca_q << 1;
			mb_q  <= mb_q >> 1;
		end
		if (cmd.mul_fin) begin
			unique case (cmd.mop)
				MOP_P:    p_q <= acc_q[PW-1:0];
				MOP_D:    d_q <= p_q - acc_q[PW-1:0];
				MOP_VSET: v_q <= VW'(signed'(acc_q));
				MOP_VADD: v_q <= v_q + VW'(signed'(acc_q));
				default:  p_q <= acc_q[PW-1:0];
			endcase
		end
		if (cmd.swap && v_q[VW-1]) begin
			c_q[1]    <= c_q[2];
			c_q[2]    <= c_q[1];
			cdat_q[1] <= cdat_q[2];
			cdat_q[2] <= cdat_q[1];
		end
		if (cmd.lk_dup) begin
			res_q[cmd.e]   <= dup_res;
			fresh_q[cmd.e] <= 1'b0;
		end
		if (cmd.lk_hit) begin
			res_q[cmd.e]   <= erd_q.node;
			fresh_q[cmd.e] <= 1'b0;
		end
		if (cmd.lk_miss) begin
			res_q[cmd.e]   <= node_need[IW-1:0];
			fresh_q[cmd.e] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			edge_count_q <= '0;
			added_q      <= '0;
		end else begin
			if (cmd.node_write || cmd.mid_write) node_count_q <= node_count_q + 1'b1;
			if (cmd.ins_write) edge_count_q <= edge_count_q + 1'b1;
			if (cmd.swap) added_q <= '0;
			else if (cmd.lk_miss) added_q <= added_q + 1'b1;
		end
	end

	// result select
	always_comb begin
		o_slot = '0;
		o_idx  = '0;
		o_new  = 1'b0;
		o_dat  = '0;
		o_last = 1'b0;
		o_err  = ERR_OK;
		unique case (cmd.esel)
			EM_NODE: begin
				o_idx   = node_count_q[IW-1:0];
				o_new   = 1'b1;
				o_dat   = in_node_q;
				o_dat.a = shown(in_node_q.a, attr_en);
				o_last  = 1'b1;
			end
			EM_CORNER: begin
				o_slot  = cmd.slot;
				o_idx   = c_q[cmd.k];
				o_dat   = cdat_q[cmd.k];
				o_dat.a = shown(cdat_q[cmd.k].a, attr_en);
			end
			EM_MID_NEW: begin
				o_slot = cmd.slot;
				o_idx  = res_q[cmd.e];
				o_new  = 1'b1;
				o_dat  = mid_ent;
				o_last = cmd.last;
			end
			EM_MID_RD: begin
				o_slot  = cmd.slot;
				o_idx   = res_q[cmd.e];
				o_dat   = nrd_q;
				o_dat.a = shown(nrd_q.a, attr_en);
				o_last  = cmd.last;
			end
			default: begin
				o_last = 1'b1;
				o_err  = cmd.err;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			slot          <= o_slot;
			node_index    <= o_idx;
			is_new        <= o_new;
			out_x         <= o_dat.x;
			out_y         <= o_dat.y;
			out_z         <= o_dat.z;
			out_attribute <= o_dat.a;
			last          <= o_last;
			error         <= o_err;
		end
	end

endmodule
`default_nettype wire
